// File: sv/c2_debug_frame_master_assert.svh
// Assertion macros used by the checker file of the C2 debug frame master.
`ifndef C2_DEBUG_FRAME_MASTER_ASSERT_SVH
`define C2_DEBUG_FRAME_MASTER_ASSERT_SVH

// Clocked assertion that is switched off while reset is asserted.
`define C2DFM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define C2DFM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/c2dfm_pkg.sv
// Package with shared types and constants of the C2 debug frame master.
`timescale 1ns / 1ps
`default_nettype none
package c2dfm_pkg;

    // Opcodes of the input channel.
    localparam logic [2:0] OP_WR_ADDR     = 3'd0;
    localparam logic [2:0] OP_RD_ADDR     = 3'd1;
    localparam logic [2:0] OP_WR_DATA     = 3'd2;
    localparam logic [2:0] OP_RD_DATA     = 3'd3;
    localparam logic [2:0] OP_STROBE_DONE = 3'd4;

    // Frame kinds, equal to the low two bits of the command opcode.
    localparam logic [1:0] KIND_AW = 2'd0;
    localparam logic [1:0] KIND_AR = 2'd1;
    localparam logic [1:0] KIND_DW = 2'd2;
    localparam logic [1:0] KIND_DR = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    // Reset value of the wait limit register.
    localparam logic [7:0] WAIT_LIMIT_RESET = 8'd20;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Class that the front gives each transfer.
    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_CMD,
        CLS_STROBE
    } item_cls_t;

    // One classified item as it sits in the queue.
    typedef struct packed {
        item_cls_t  cls;
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       sample;
    } item_t;

    // Head of the queue as seen by the back.
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

endpackage
`default_nettype wire

// File: sv/c2_debug_frame_master.sv
// Top level of the C2 debug frame master: front queue and frame sequencer.
// The host side of a two-wire C2 debug link. Each input transfer is either a
// command (write or read address, write or read data) that opens a frame, or
// a report that the strobe last asked for has completed, with the sampled
// data line level. Each input transfer yields exactly one result transfer that
// tells the strobe engine whether to strobe next and with what drive, and on
// the last item of a frame carries done, the read byte and the status.
// Both channels use valid and stall; a transfer happens when valid is high and
// stall is low. The wait limit register is written by cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; the block does not
// enforce this. An input transfer is written to the queue and its result is
// then registered; one item per cycle is sustained while out_stall is low.
// A two-entry queue sits between front and sequencer, so input keeps flowing
// for two items while the result side stalls; after that in_stall rises.
// Reset empties the queue and result register, returns the frame to idle and
// sets the wait limit to 20.
`timescale 1ns / 1ps
`default_nettype none
module c2_debug_frame_master (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  opcode,
    input  wire logic [7:0]  data_byte,
    input  wire logic        c2d_sample,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             c2d_release,
    output logic             do_strobe,
    output logic             busy_res,
    output logic             done_res,
    output logic [7:0]       read_byte,
    output logic [1:0]       status
);

    c2dfm_pkg::queue_head_t head;
    logic                   pop;

    // Classification and queue.
    c2dfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .data_byte  (data_byte),
        .c2d_sample (c2d_sample),
        .head       (head),
        .pop        (pop)
    );

    // Frame sequencer and result register.
    c2dfm_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .c2d_release (c2d_release),
        .do_strobe   (do_strobe),
        .busy_res    (busy_res),
        .done_res    (done_res),
        .read_byte   (read_byte),
        .status      (status)
    );

endmodule
`default_nettype wire

// File: sv/c2dfm_front.sv
// Front of the C2 debug frame master: classifies input transfers into a short queue.
`timescale 1ns / 1ps
`default_nettype none
module c2dfm_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2:0]           opcode,
    input  wire logic [7:0]           data_byte,
    input  wire logic                 c2d_sample,
    output c2dfm_pkg::queue_head_t    head,
    input  wire logic                 pop
);

    localparam int PtrW = (c2dfm_pkg::QUEUE_DEPTH > 1) ? $clog2(c2dfm_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(c2dfm_pkg::QUEUE_DEPTH + 1);

    c2dfm_pkg::item_t  slot_reg [c2dfm_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]   wr_ptr_reg;
    logic [PtrW-1:0]   wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg;
    logic [PtrW-1:0]   rd_ptr_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    c2dfm_pkg::item_t  new_item;
    logic              push;
    logic              do_pop;

    // Classify the incoming opcode.
    always_comb
    begin
        new_item.kind      = opcode[1:0];
        new_item.data_byte = data_byte;
        new_item.sample    = c2d_sample;
        if (opcode == c2dfm_pkg::OP_WR_ADDR || opcode == c2dfm_pkg::OP_RD_ADDR ||
            opcode == c2dfm_pkg::OP_WR_DATA || opcode == c2dfm_pkg::OP_RD_DATA)
        begin
            new_item.cls = c2dfm_pkg::CLS_CMD;
        end
        else if (opcode == c2dfm_pkg::OP_STROBE_DONE)
        begin
            new_item.cls = c2dfm_pkg::CLS_STROBE;
        end
        else
        begin
            new_item.cls = c2dfm_pkg::CLS_NONE;
        end
    end

    // Queue control.
    assign in_stall = (count_reg == CntW'(c2dfm_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign do_pop   = pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(c2dfm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(c2dfm_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntW'(push) - CntW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = slot_reg[rd_ptr_reg];

endmodule
`default_nettype wire

// File: sv/c2dfm_back.sv
// Back of the C2 debug frame master: frame sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none
module c2dfm_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [7:0]           cfg_wr_data,
    input  wire c2dfm_pkg::queue_head_t head,
    output logic                      pop,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      c2d_release,
    output logic                      do_strobe,
    output logic                      busy_res,
    output logic                      done_res,
    output logic [7:0]                read_byte,
    output logic [1:0]                status
);

    // Field of the strobe last requested.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_INS,
        PH_LEN,
        PH_WBYTE,
        PH_WAIT,
        PH_RBYTE,
        PH_STOP
    } phase_t;

    phase_t      phase_reg,      phase_next;
    logic [1:0]  kind_reg,       kind_next;
    logic [2:0]  bit_cnt_reg,    bit_cnt_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic [7:0]  wait_cnt_reg,   wait_cnt_next;
    logic [7:0]  wait_limit_reg;
    logic        out_valid_reg,  out_valid_next;
    logic        rel_reg,        rel_next;
    logic        stb_reg,        stb_next;
    logic        busy_reg,       busy_next;
    logic        done_reg,       done_next;
    logic [7:0]  rbyte_reg,      rbyte_next;
    logic [1:0]  status_reg,     status_next;
    logic [1:0]  ins;
    logic [7:0]  shifted_in;

    // An item leaves the queue whenever the result register can take its result.
    assign pop = head.valid && (!out_valid_reg || !out_stall);

    // Instruction code of the current frame and the read shift with the new sample.
    assign ins        = 2'd3 - kind_reg;
    assign shifted_in = {head.item.sample, shift_byte_reg[7:1]};

    // Frame sequencing for the item at the head of the queue.
    always_comb
    begin
        phase_next      = phase_reg;
        kind_next       = kind_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_byte_next = shift_byte_reg;
        wait_cnt_next   = wait_cnt_reg;
        rel_next        = 1'b1;
        stb_next        = 1'b0;
        done_next       = 1'b0;
        rbyte_next      = '0;
        status_next     = c2dfm_pkg::ST_OK;

        unique case (head.item.cls)
            c2dfm_pkg::CLS_CMD:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    kind_next       = head.item.kind;
                    shift_byte_next = (head.item.kind == c2dfm_pkg::KIND_AW ||
                                       head.item.kind == c2dfm_pkg::KIND_DW) ?
                                      head.item.data_byte : 8'd0;
                    wait_cnt_next   = '0;
                    stb_next        = 1'b1;
                    phase_next      = PH_START;
                    bit_cnt_next    = '0;
                end
                else
                begin
                    status_next = c2dfm_pkg::ST_REFUSED;
                end
            end
            c2dfm_pkg::CLS_STROBE:
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_START:
                    begin
                        stb_next     = 1'b1;
                        rel_next     = ins[0];
                        phase_next   = PH_INS;
                        bit_cnt_next = '0;
                    end
                    PH_INS:
                    begin
                        stb_next     = 1'b1;
                        bit_cnt_next = '0;
                        if (bit_cnt_reg == 3'd0)
                        begin
                            rel_next     = ins[1];
                            phase_next   = PH_INS;
                            bit_cnt_next = 3'd1;
                        end
                        else if (kind_reg == c2dfm_pkg::KIND_AW)
                        begin
                            rel_next        = shift_byte_reg[0];
                            shift_byte_next = shift_byte_reg >> 1;
                            phase_next      = PH_WBYTE;
                        end
                        else if (kind_reg == c2dfm_pkg::KIND_AR)
                        begin
                            phase_next = PH_RBYTE;
                        end
                        else
                        begin
                            rel_next   = 1'b0;
                            phase_next = PH_LEN;
                        end
                    end
                    PH_LEN:
                    begin
                        stb_next     = 1'b1;
                        bit_cnt_next = '0;
                        if (bit_cnt_reg == 3'd0)
                        begin
                            rel_next     = 1'b0;
                            bit_cnt_next = 3'd1;
                        end
                        else if (kind_reg == c2dfm_pkg::KIND_DW)
                        begin
                            rel_next        = shift_byte_reg[0];
                            shift_byte_next = shift_byte_reg >> 1;
                            phase_next      = PH_WBYTE;
                        end
                        else
                        begin
                            wait_cnt_next = 8'd1;
                            phase_next    = PH_WAIT;
                        end
                    end
                    PH_WBYTE:
                    begin
                        stb_next     = 1'b1;
                        bit_cnt_next = '0;
                        if (bit_cnt_reg != 3'd7)
                        begin
                            rel_next        = shift_byte_reg[0];
                            shift_byte_next = shift_byte_reg >> 1;
                            bit_cnt_next    = bit_cnt_reg + 3'd1;
                        end
                        else if (kind_reg == c2dfm_pkg::KIND_DW)
                        begin
                            wait_cnt_next = 8'd1;
                            phase_next    = PH_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_STOP;
                        end
                    end
                    PH_WAIT:
                    begin
                        bit_cnt_next = '0;
                        if (head.item.sample)
                        begin
                            stb_next   = 1'b1;
                            phase_next = (kind_reg == c2dfm_pkg::KIND_DR) ? PH_RBYTE : PH_STOP;
                        end
                        else if (wait_cnt_reg >= wait_limit_reg)
                        begin
                            // Target never left the wait field: give up without STOP.
                            done_next   = 1'b1;
                            status_next = c2dfm_pkg::ST_TIMEOUT;
                            phase_next  = PH_IDLE;
                        end
                        else
                        begin
                            stb_next      = 1'b1;
                            wait_cnt_next = wait_cnt_reg + 8'd1;
                        end
                    end
                    PH_RBYTE:
                    begin
                        stb_next        = 1'b1;
                        shift_byte_next = shifted_in;
                        if (bit_cnt_reg != 3'd7)
                        begin
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                        end
                        else
                        begin
                            bit_cnt_next = '0;
                            phase_next   = PH_STOP;
                        end
                    end
                    PH_STOP:
                    begin
                        done_next    = 1'b1;
                        rbyte_next   = (kind_reg == c2dfm_pkg::KIND_AR ||
                                        kind_reg == c2dfm_pkg::KIND_DR) ? shift_byte_reg : 8'd0;
                        phase_next   = PH_IDLE;
                        bit_cnt_next = '0;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        busy_next      = (phase_next != PH_IDLE);
        out_valid_next = pop ? 1'b1 : (out_valid_reg && out_stall);
    end

    // Sequencer state, wait limit and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            kind_reg       <= '0;
            bit_cnt_reg    <= '0;
            shift_byte_reg <= '0;
            wait_cnt_reg   <= '0;
            wait_limit_reg <= c2dfm_pkg::WAIT_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
            rel_reg        <= 1'b1;
            stb_reg        <= 1'b0;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            rbyte_reg      <= '0;
            status_reg     <= c2dfm_pkg::ST_OK;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                wait_limit_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg      <= phase_next;
                kind_reg       <= kind_next;
                bit_cnt_reg    <= bit_cnt_next;
                shift_byte_reg <= shift_byte_next;
                wait_cnt_reg   <= wait_cnt_next;
                rel_reg        <= rel_next;
                stb_reg        <= stb_next;
                busy_reg       <= busy_next;
                done_reg       <= done_next;
                rbyte_reg      <= rbyte_next;
                status_reg     <= status_next;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign c2d_release = rel_reg;
    assign do_strobe   = stb_reg;
    assign busy_res    = busy_reg;
    assign done_res    = done_reg;
    assign read_byte   = rbyte_reg;
    assign status      = status_reg;

endmodule
`default_nettype wire

// File: sv/c2dfm_checker.sv
// Port-level checker of the C2 debug frame master and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "c2_debug_frame_master_assert.svh"
module c2dfm_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        c2d_release,
    input wire logic        do_strobe,
    input wire logic        busy_res,
    input wire logic        done_res,
    input wire logic [7:0]  read_byte,
    input wire logic [1:0]  status
);

    // A stalled result holds its payload.
    `C2DFM_ASSERT(a_stall_hold,
        out_valid && out_stall |=> out_valid && $stable(c2d_release) && $stable(do_strobe)
            && $stable(status) && $stable(read_byte),
        "stalled result changed")

    // The line is released whenever no strobe is asked for.
    `C2DFM_ASSERT(a_release_idle, out_valid && !do_strobe |-> c2d_release,
        "line driven low without a strobe")

    // A finished frame neither strobes nor stays busy.
    `C2DFM_ASSERT(a_done_idle, out_valid && done_res |-> !do_strobe && !busy_res,
        "done result still strobing or busy")

    // A refused command leaves the frame running and asks for nothing.
    `C2DFM_ASSERT(a_refused,
        out_valid && status == c2dfm_pkg::ST_REFUSED |-> busy_res && !do_strobe && !done_res,
        "refused command disturbed the frame")

    // A timeout or a read byte appears only on a done result.
    `C2DFM_ASSERT(a_done_only,
        out_valid && (status == c2dfm_pkg::ST_TIMEOUT || read_byte != 8'd0) |-> done_res,
        "timeout or read byte without done")

endmodule

bind c2_debug_frame_master c2dfm_checker u_c2dfm_checker (.*);
`default_nettype wire
